### rtl/twb_pkg.sv
package twb_pkg;

    // Defaults for the top-level parameters.
    localparam int DEF_BUCKET_DEPTH = 16;
    localparam int DEF_ID_WIDTH     = 16;
    localparam int DEF_TICK_WIDTH   = 48;

    // Fixed widths of the transaction fields.
    localparam int OPCODE_W   = 2;
    localparam int ID_FIELD_W = 16;
    localparam int ROUNDS_W   = 16;
    localparam int TICK_FIELD_W = 48;
    localparam int KIND_W     = 3;

    typedef enum logic [OPCODE_W-1:0] {
        OP_ADD    = 2'd0,
        OP_REMOVE = 2'd1,
        OP_EXPIRE = 2'd2,
        OP_CLEAR  = 2'd3
    } t_opcode;

    typedef enum logic [KIND_W-1:0] {
        KIND_ADDED     = 3'd0,
        KIND_FULL      = 3'd1,
        KIND_DUPLICATE = 3'd2,
        KIND_REMOVED   = 3'd3,
        KIND_NOT_FOUND = 3'd4,
        KIND_EXPIRED   = 3'd5,
        KIND_MISPLACED = 3'd6,
        KIND_DRAINED   = 3'd7
    } t_kind;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PASS,
        ST_FINISH
    } t_state;

    // Per-cycle command shared by every cell of the chain.
    typedef struct packed {
        logic shift;   // every cell takes its upper neighbour, the head leaves
        logic push;    // an entry joins just above the last valid cell
    } t_cell_ctrl;

endpackage

### rtl/twb_op_if.sv
interface twb_op_if
    import twb_pkg::*;
;
    logic                    valid;
    logic                    ready;
    logic [OPCODE_W-1:0]     opcode;
    logic [ID_FIELD_W-1:0]   entry_id;
    logic [ROUNDS_W-1:0]     rounds_left;
    logic [TICK_FIELD_W-1:0] entry_deadline;
    logic [TICK_FIELD_W-1:0] now_tick;

    modport source (
        output valid, opcode, entry_id, rounds_left, entry_deadline, now_tick,
        input  ready
    );

    modport sink (
        input  valid, opcode, entry_id, rounds_left, entry_deadline, now_tick,
        output ready
    );
endinterface

### rtl/twb_res_if.sv
interface twb_res_if
    import twb_pkg::*;
;
    logic                    valid;
    logic                    ready;
    logic [KIND_W-1:0]       result_kind;
    logic [ID_FIELD_W-1:0]   out_id;
    logic [TICK_FIELD_W-1:0] out_deadline;
    logic                    done_res;
    logic                    has_entry;

    modport source (
        output valid, result_kind, out_id, out_deadline, done_res, has_entry,
        input  ready
    );

    modport sink (
        input  valid, result_kind, out_id, out_deadline, done_res, has_entry,
        output ready
    );
endinterface

### rtl/twb_cell.sv
module twb_cell
    import twb_pkg::*;
#(
    parameter int ID_WIDTH   = DEF_ID_WIDTH,
    parameter int TICK_WIDTH = DEF_TICK_WIDTH
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_cell_ctrl            i_ctrl,
    input  logic                  i_prev_valid,
    input  logic                  i_next_valid,
    input  logic [ID_WIDTH-1:0]   i_next_id,
    input  logic [ROUNDS_W-1:0]   i_next_rounds,
    input  logic [TICK_WIDTH-1:0] i_next_dl,
    input  logic [ID_WIDTH-1:0]   i_push_id,
    input  logic [ROUNDS_W-1:0]   i_push_rounds,
    input  logic [TICK_WIDTH-1:0] i_push_dl,
    output logic                  o_valid,
    output logic [ID_WIDTH-1:0]   o_id,
    output logic [ROUNDS_W-1:0]   o_rounds,
    output logic [TICK_WIDTH-1:0] o_dl
);

    logic                  r_valid, n_valid;
    logic [ID_WIDTH-1:0]   r_id, n_id;
    logic [ROUNDS_W-1:0]   r_rounds, n_rounds;
    logic [TICK_WIDTH-1:0] r_dl, n_dl;

    // A shift moves the list one cell towards the head. A push lands in the
    // first free cell, which after a shift is the old last valid cell.
    always_comb begin
        n_valid  = r_valid;
        n_id     = r_id;
        n_rounds = r_rounds;
        n_dl     = r_dl;
        if (i_ctrl.shift) begin
            n_valid  = i_next_valid;
            n_id     = i_next_id;
            n_rounds = i_next_rounds;
            n_dl     = i_next_dl;
            if (i_ctrl.push && r_valid && !i_next_valid) begin
                n_valid  = 1'b1;
                n_id     = i_push_id;
                n_rounds = i_push_rounds;
                n_dl     = i_push_dl;
            end
        end else if (i_ctrl.push && !r_valid && i_prev_valid) begin
            n_valid  = 1'b1;
            n_id     = i_push_id;
            n_rounds = i_push_rounds;
            n_dl     = i_push_dl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_id     <= n_id;
        r_rounds <= n_rounds;
        r_dl     <= n_dl;
    end

    assign o_valid  = r_valid;
    assign o_id     = r_id;
    assign o_rounds = r_rounds;
    assign o_dl     = r_dl;

endmodule

### rtl/timer_wheel_bucket.sv
// One bucket of a hashed timing wheel: up to BUCKET_DEPTH pending timeouts
// kept oldest first in a chain of cells, and one operation per input
// transaction (add, remove by id, expire tick, clear). Every operation runs
// the stored entries past the head of the chain one per cycle while the
// result register is free, so back-pressure holds a pass. An operation is
// accepted, takes one step for each entry stored at the start of the
// operation, finds no steps left and loads the final result once the
// result register is free; a pass has at most BUCKET_DEPTH steps. The next
// operation is accepted in the cycle after the final result has been
// loaded, so results never overlap.
// Add and remove return a single result transaction; expire and clear return
// one transaction for each reported entry followed by a done marker with
// has_entry low. The bucket is empty after reset and needs no clearing pass.
module timer_wheel_bucket
    import twb_pkg::*;
#(
    parameter int BUCKET_DEPTH = DEF_BUCKET_DEPTH,
    parameter int ID_WIDTH     = DEF_ID_WIDTH,
    parameter int TICK_WIDTH   = DEF_TICK_WIDTH
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    twb_op_if.sink       i_op,
    twb_res_if.source    o_res
);

    localparam int CNT_W = $clog2(BUCKET_DEPTH + 1);

    // Control and the captured operation.
    t_state                r_state, n_state;
    t_opcode               r_op, n_op;
    logic [ID_WIDTH-1:0]   r_id, n_id;
    logic [ROUNDS_W-1:0]   r_rounds, n_rounds;
    logic [TICK_WIDTH-1:0] r_deadline, n_deadline;
    logic [TICK_WIDTH-1:0] r_now, n_now;
    logic [CNT_W-1:0]      r_left, n_left;
    logic [CNT_W-1:0]      r_count, n_count;
    logic                  r_hit, n_hit;
    logic [TICK_WIDTH-1:0] r_hit_dl, n_hit_dl;

    // Result register, which parts the result channel from the chain.
    logic                    r_out_valid, n_out_valid;
    t_kind                   r_out_kind, n_out_kind;
    logic [ID_FIELD_W-1:0]   r_out_id, n_out_id;
    logic [TICK_FIELD_W-1:0] r_out_dl, n_out_dl;
    logic                    r_out_done, n_out_done;
    logic                    r_out_has, n_out_has;

    // Chain of cells; cell 0 is the head, the oldest entry.
    t_cell_ctrl            w_ctrl;
    logic [BUCKET_DEPTH-1:0] w_valid;
    logic [ID_WIDTH-1:0]   w_id     [BUCKET_DEPTH];
    logic [ROUNDS_W-1:0]   w_rounds [BUCKET_DEPTH];
    logic [TICK_WIDTH-1:0] w_dl     [BUCKET_DEPTH];
    logic [ID_WIDTH-1:0]   w_push_id;
    logic [ROUNDS_W-1:0]   w_push_rounds;
    logic [TICK_WIDTH-1:0] w_push_dl;
    logic                  w_out_free;
    logic                  w_op_ready;

    for (genvar g = 0; g < BUCKET_DEPTH; g++) begin : g_cell
        logic                  w_prev_valid;
        logic                  w_next_valid;
        logic [ID_WIDTH-1:0]   w_next_id;
        logic [ROUNDS_W-1:0]   w_next_rounds;
        logic [TICK_WIDTH-1:0] w_next_dl;

        if (g == 0) begin : g_first
            assign w_prev_valid = 1'b1;
        end else begin : g_inner
            assign w_prev_valid = w_valid[g-1];
        end

        if (g == BUCKET_DEPTH - 1) begin : g_last
            assign w_next_valid  = 1'b0;
            assign w_next_id     = '0;
            assign w_next_rounds = '0;
            assign w_next_dl     = '0;
        end else begin : g_body
            assign w_next_valid  = w_valid[g+1];
            assign w_next_id     = w_id[g+1];
            assign w_next_rounds = w_rounds[g+1];
            assign w_next_dl     = w_dl[g+1];
        end

        twb_cell #(
            .ID_WIDTH   (ID_WIDTH),
            .TICK_WIDTH (TICK_WIDTH)
        ) u_cell (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_ctrl        (w_ctrl),
            .i_prev_valid  (w_prev_valid),
            .i_next_valid  (w_next_valid),
            .i_next_id     (w_next_id),
            .i_next_rounds (w_next_rounds),
            .i_next_dl     (w_next_dl),
            .i_push_id     (w_push_id),
            .i_push_rounds (w_push_rounds),
            .i_push_dl     (w_push_dl),
            .o_valid       (w_valid[g]),
            .o_id          (w_id[g]),
            .o_rounds      (w_rounds[g]),
            .o_dl          (w_dl[g])
        );
    end

    // The result register can take a new transaction when it is empty or
    // its current one is being taken in this cycle.
    assign w_out_free = !r_out_valid || o_res.ready;

    // During a pass the head entry either leaves the chain (it is reported
    // or removed) or is pushed straight back in behind the last entry, so
    // after entry_count steps the kept entries stand in their old order.
    always_comb begin
        n_state     = r_state;
        n_op        = r_op;
        n_id        = r_id;
        n_rounds    = r_rounds;
        n_deadline  = r_deadline;
        n_now       = r_now;
        n_left      = r_left;
        n_count     = r_count;
        n_hit       = r_hit;
        n_hit_dl    = r_hit_dl;
        n_out_valid = r_out_valid && !o_res.ready;
        n_out_kind  = r_out_kind;
        n_out_id    = r_out_id;
        n_out_dl    = r_out_dl;
        n_out_done  = r_out_done;
        n_out_has   = r_out_has;
        w_ctrl        = '0;
        w_push_id     = w_id[0];
        w_push_rounds = w_rounds[0];
        w_push_dl     = w_dl[0];
        w_op_ready    = 1'b0;

        unique case (r_state)
            ST_IDLE: begin
                w_op_ready = 1'b1;
                if (i_op.valid) begin
                    n_op       = t_opcode'(i_op.opcode);
                    n_id       = ID_WIDTH'(i_op.entry_id);
                    n_rounds   = i_op.rounds_left;
                    n_deadline = TICK_WIDTH'(i_op.entry_deadline);
                    n_now      = TICK_WIDTH'(i_op.now_tick);
                    n_left     = r_count;
                    n_hit      = 1'b0;
                    n_state    = ST_PASS;
                end
            end

            ST_PASS: begin
                if (r_left == '0) begin
                    n_state = ST_FINISH;
                end else if (w_out_free) begin
                    w_ctrl.shift = 1'b1;
                    n_left       = r_left - 1'b1;
                    case (r_op)
                        OP_ADD: begin
                            w_ctrl.push = 1'b1;
                            if (w_id[0] == r_id) begin
                                n_hit    = 1'b1;
                                n_hit_dl = w_dl[0];
                            end
                        end
                        OP_REMOVE: begin
                            if (w_id[0] == r_id && !r_hit) begin
                                n_hit    = 1'b1;
                                n_hit_dl = w_dl[0];
                                n_count  = r_count - 1'b1;
                            end else begin
                                w_ctrl.push = 1'b1;
                            end
                        end
                        OP_EXPIRE: begin
                            if (w_rounds[0] == '0) begin
                                n_count     = r_count - 1'b1;
                                n_out_valid = 1'b1;
                                n_out_kind  = (w_dl[0] <= r_now) ? KIND_EXPIRED
                                                                  : KIND_MISPLACED;
                                n_out_id    = ID_FIELD_W'(w_id[0]);
                                n_out_dl    = TICK_FIELD_W'(w_dl[0]);
                                n_out_done  = 1'b0;
                                n_out_has   = 1'b1;
                            end else begin
                                w_ctrl.push   = 1'b1;
                                w_push_rounds = w_rounds[0] - 1'b1;
                            end
                        end
                        OP_CLEAR: begin
                            n_count     = r_count - 1'b1;
                            n_out_valid = 1'b1;
                            n_out_kind  = KIND_DRAINED;
                            n_out_id    = ID_FIELD_W'(w_id[0]);
                            n_out_dl    = TICK_FIELD_W'(w_dl[0]);
                            n_out_done  = 1'b0;
                            n_out_has   = 1'b1;
                        end
                        default: begin
                        end
                    endcase
                end
            end

            ST_FINISH: begin
                if (w_out_free) begin
                    n_state     = ST_IDLE;
                    n_out_valid = 1'b1;
                    n_out_done  = 1'b1;
                    n_out_has   = 1'b0;
                    n_out_id    = '0;
                    n_out_dl    = '0;
                    case (r_op)
                        OP_ADD: begin
                            if (r_hit) begin
                                n_out_kind = KIND_DUPLICATE;
                                n_out_id   = ID_FIELD_W'(r_id);
                                n_out_dl   = TICK_FIELD_W'(r_hit_dl);
                                n_out_has  = 1'b1;
                            end else if (r_count == CNT_W'(BUCKET_DEPTH)) begin
                                n_out_kind = KIND_FULL;
                            end else begin
                                w_ctrl.push   = 1'b1;
                                w_push_id     = r_id;
                                w_push_rounds = r_rounds;
                                w_push_dl     = r_deadline;
                                n_count       = r_count + 1'b1;
                                n_out_kind    = KIND_ADDED;
                                n_out_id      = ID_FIELD_W'(r_id);
                                n_out_dl      = TICK_FIELD_W'(r_deadline);
                                n_out_has     = 1'b1;
                            end
                        end
                        OP_REMOVE: begin
                            if (r_hit) begin
                                n_out_kind = KIND_REMOVED;
                                n_out_id   = ID_FIELD_W'(r_id);
                                n_out_dl   = TICK_FIELD_W'(r_hit_dl);
                                n_out_has  = 1'b1;
                            end else begin
                                n_out_kind = KIND_NOT_FOUND;
                            end
                        end
                        OP_EXPIRE: begin
                            n_out_kind = KIND_EXPIRED;
                        end
                        OP_CLEAR: begin
                            n_out_kind = KIND_DRAINED;
                        end
                        default: begin
                        end
                    endcase
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op       <= n_op;
        r_id       <= n_id;
        r_rounds   <= n_rounds;
        r_deadline <= n_deadline;
        r_now      <= n_now;
        r_left     <= n_left;
        r_hit      <= n_hit;
        r_hit_dl   <= n_hit_dl;
        r_out_kind <= n_out_kind;
        r_out_id   <= n_out_id;
        r_out_dl   <= n_out_dl;
        r_out_done <= n_out_done;
        r_out_has  <= n_out_has;
    end

    assign i_op.ready         = w_op_ready;
    assign o_res.valid        = r_out_valid;
    assign o_res.result_kind  = r_out_kind;
    assign o_res.out_id       = r_out_id;
    assign o_res.out_deadline = r_out_dl;
    assign o_res.done_res     = r_out_done;
    assign o_res.has_entry    = r_out_has;

`ifndef SYNTHESIS
    // The entry count always matches the number of occupied cells.
    a_count_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(w_valid) == 32'(r_count))
        else $error("entry count differs from occupied cells");

    // Occupied cells form an unbroken run starting at the head.
    a_packed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_valid & (w_valid + 1'b1)) == '0)
        else $error("occupied cells are not packed at the head");

    // A pass never has more steps left than entries stored.
    a_left_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_PASS |-> r_left <= r_count)
        else $error("pass step count exceeds stored entries");

    // Only a final result may come without an entry.
    a_marker_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_out_has |-> r_out_done)
        else $error("entry-less result not marked as final");

    // An add that stores an entry raises the count by one.
    a_add_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_FINISH && w_out_free && r_op == OP_ADD && !r_hit &&
        r_count != CNT_W'(BUCKET_DEPTH) |=> r_count == $past(r_count) + 1'b1)
        else $error("add did not grow the bucket");
`endif

endmodule
